/* rtl/knx_trc_pkg.sv */
package knx_trc_pkg;

  // Default frame geometry
  localparam int HEADER_BYTES_DEF       = 6;
  localparam int MAX_TELEGRAM_BYTES_DEF = 23;

  // Header bytes kept for decoding
  localparam int STORE_DEPTH = 8;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int POS_W       = 5;

  // Byte positions inside the header
  localparam logic [POS_W-1:0] POS_CTRL = POS_W'(0);
  localparam logic [POS_W-1:0] POS_NPCI = POS_W'(5);

  localparam logic [7:0] CHECK_INIT = 8'hFF;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } knx_in_t;

  typedef struct packed {
    logic        checksum_ok;
    logic        repeated;
    logic [1:0]  priority_res;
    logic [15:0] source_address;
    logic        target_is_group;
    logic [15:0] target_address;
    logic [2:0]  hop_count;
    logic [4:0]  payload_length;
    logic [1:0]  comm_type;
    logic [3:0]  sequence_number;
    logic [3:0]  command;
    logic [5:0]  first_data;
  } knx_out_t;

endpackage

/* rtl/knx_telegram_receive_checker.sv */
// Pipeline: an accepted request is held in the input register and processed from there; its
//   result is loaded into the output register once that register is free.
// Throughput: one request per cycle, unless a result byte is held by a stalled output;
//   the single state-update stage closes the byte index / running XOR loop.
// Reset (rst_n low, synchronous): no frame open, byte index 0, running check 0xFF, both
//   stages empty. The header bytes are not cleared; every byte read is written first.
module knx_telegram_receive_checker #(
  parameter int HEADER_BYTES       = knx_trc_pkg::HEADER_BYTES_DEF,
  parameter int MAX_TELEGRAM_BYTES = knx_trc_pkg::MAX_TELEGRAM_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  knx_trc_pkg::knx_in_t in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output knx_trc_pkg::knx_out_t out_data
);

  localparam int PW = knx_trc_pkg::POS_W;

  // ---------------------------------------------------------------------------
  // Input register stage
  // ---------------------------------------------------------------------------
  logic                 s1_valid_r, s1_valid_nxt;
  knx_trc_pkg::knx_in_t s1_data_r;
  logic                 s1_fire;
  logic                 in_take;

  // ---------------------------------------------------------------------------
  // Frame state
  // ---------------------------------------------------------------------------
  logic          in_frame_r, in_frame_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0]    check_r, check_nxt;
  logic [7:0]    hdr_r [knx_trc_pkg::STORE_DEPTH];

  // Output register
  logic                  out_valid_r, out_valid_nxt;
  knx_trc_pkg::knx_out_t out_data_r, res;

  // Working values for the byte in the input register
  logic          frame_act;
  logic [PW-1:0] pos_eff;
  logic [7:0]    check_eff;
  logic [PW:0]   check_pos;
  logic [PW:0]   pos_inc;
  logic          emit;
  logic          too_long;
  logic          out_free;
  logic          hdr_we;
  logic [4:0]    plen;

  // A start byte reopens the frame at position 0 regardless of any frame in progress
  assign frame_act = s1_data_r.frame_start | in_frame_r;
  assign pos_eff   = s1_data_r.frame_start ? '0 : pos_r;
  assign check_eff = s1_data_r.frame_start ? knx_trc_pkg::CHECK_INIT : check_r;

  // Check byte position: header, then payload length (low nibble of byte 5, plus one)
  assign plen      = {1'b0, hdr_r[knx_trc_pkg::POS_NPCI[knx_trc_pkg::STORE_AW-1:0]][3:0]}
                     + 5'd1;
  assign check_pos = (PW+1)'(HEADER_BYTES) + {1'b0, plen};
  assign emit      = frame_act && (pos_eff > knx_trc_pkg::POS_NPCI)
                     && ({1'b0, pos_eff} == check_pos);

  // Overlong frame: next position would reach the telegram limit
  assign pos_inc   = {1'b0, pos_eff} + (PW+1)'(1);
  assign too_long  = (pos_inc >= (PW+1)'(MAX_TELEGRAM_BYTES)) || pos_inc[PW];

  assign hdr_we    = (pos_eff < PW'(knx_trc_pkg::STORE_DEPTH));

  // Handshake: the result path only blocks a byte that actually produces a result
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && (!emit || out_free);
  assign in_stall  = s1_valid_r && !s1_fire;
  assign in_take   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = in_take ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
  end

  always_comb begin
    in_frame_nxt = in_frame_r;
    pos_nxt      = pos_r;
    check_nxt    = check_r;
    if (s1_fire && frame_act) begin
      if (emit) begin
        in_frame_nxt = 1'b0;
      end else begin
        check_nxt = check_eff ^ s1_data_r.rx_byte;
        if (too_long) begin
          in_frame_nxt = 1'b0;
          pos_nxt      = pos_eff;
        end else begin
          in_frame_nxt = 1'b1;
          pos_nxt      = pos_inc[PW-1:0];
        end
      end
    end
  end

  // Header decode; command and first data only exist for payloads longer than one byte
  always_comb begin
    res                 = '0;
    res.checksum_ok     = (s1_data_r.rx_byte == check_eff);
    res.repeated        = ~hdr_r[0][5];
    res.priority_res    = hdr_r[0][3:2];
    res.source_address  = {hdr_r[1], hdr_r[2]};
    res.target_is_group = hdr_r[5][7];
    res.target_address  = {hdr_r[3], hdr_r[4]};
    res.hop_count       = hdr_r[5][6:4];
    res.payload_length  = plen;
    res.comm_type       = hdr_r[6][7:6];
    res.sequence_number = hdr_r[6][5:2];
    if (plen > 5'd1) begin
      res.command    = {hdr_r[6][1:0], hdr_r[7][7:6]};
      res.first_data = hdr_r[7][5:0];
    end
  end

  always_comb begin
    if (s1_fire && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      in_frame_r  <= 1'b0;
      pos_r       <= '0;
      check_r     <= knx_trc_pkg::CHECK_INIT;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      in_frame_r  <= in_frame_nxt;
      pos_r       <= pos_nxt;
      check_r     <= check_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (s1_fire && frame_act && !emit && hdr_we) begin
      hdr_r[pos_eff[knx_trc_pkg::STORE_AW-1:0]] <= s1_data_r.rx_byte;
    end
    if (s1_fire && emit) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_close_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && emit) |=> (!in_frame_r && out_valid_r))
    else $error("frame still open after its result");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_frame_r |-> ({1'b0, pos_r} < (PW+1)'(MAX_TELEGRAM_BYTES)))
    else $error("byte index beyond telegram limit");

  a_no_skip_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_frame_r && (pos_r > knx_trc_pkg::POS_NPCI)) |-> ({1'b0, pos_r} <= check_pos))
    else $error("byte index ran past the check byte");

  a_stall_on_blocked_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && emit && out_valid_r && out_stall) |-> in_stall)
    else $error("result dropped while output held");

endmodule
